[rtl/core/swrl_pkg.sv]
package swrl_pkg;

  localparam int CLIENTS = 16;
  localparam int ENTRIES = 16;
  localparam int DEPTH = CLIENTS * ENTRIES;

  localparam int CLIENT_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd1;

  localparam logic [4:0] DEFAULT_LIMIT_RESET = 5'd10;
  localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd1000;

  typedef struct packed {
    logic [3:0]  client_index;
    logic [4:0]  request_limit;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [4:0] in_window_count;
  } rsp_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [CNT_W-1:0]    limit;
    logic [31:0]         now;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_DECIDE
  } state_t;

  // Client index reduced modulo CLIENTS through a sixteen-entry table.
  function automatic logic [CLIENT_W-1:0] client_of(input logic [3:0] idx);
    logic [CLIENT_W-1:0] r;
    r = '0;
    for (int v = 0; v < 16; v++) begin
      if (idx == 4'(v)) begin
        r = CLIENT_W'(v % CLIENTS);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/swrl_front.sv]
module swrl_front
  import swrl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  req_t       request,
  input  logic [4:0] default_limit,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  cmd_t       buf_q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic [4:0] raw_limit;
  cmd_t       cmd_in;

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = buf_q[rd_ptr];
  assign do_push = push && !full;

  // A zero request limit selects the default, and the result saturates at the ring depth.
  always_comb begin
    raw_limit = (request.request_limit != 5'd0) ? request.request_limit : default_limit;
    cmd_in.client = client_of(request.client_index);
    if (32'(raw_limit) > ENTRIES) begin
      cmd_in.limit = CNT_W'(ENTRIES);
    end else begin
      cmd_in.limit = CNT_W'(raw_limit);
    end
    cmd_in.now = request.now_time;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !cmd_take) begin
        cnt <= cnt + 2'd1;
      end else if (!do_push && cmd_take) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

[rtl/core/swrl_back.sv]
module swrl_back
  import swrl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  input  logic [31:0] window_length,
  output logic        empty,
  input  logic        pop,
  output rsp_t        result
);

  state_t state;
  state_t state_next;

  logic [SLOT_W-1:0] ring_head  [CLIENTS];
  logic [CNT_W-1:0]  ring_count [CLIENTS];
  logic [31:0]       mem [DEPTH];
  logic [31:0]       mem_q;

  logic [CLIENT_W-1:0] st_client;
  logic [CNT_W-1:0]    st_limit;
  logic [31:0]         st_now;
  logic [SLOT_W-1:0]   wh;
  logic [SLOT_W-1:0]   wh_next;
  logic [CNT_W-1:0]    wc;
  logic [CNT_W-1:0]    wc_next;

  logic              mem_rd;
  logic              mem_wr;
  logic              ring_upd;
  logic              res_push;
  logic              res_allowed;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [SLOT_W-1:0] tail_slot;
  logic [31:0]       tail_sum;
  logic [31:0]       age;

  rsp_t       res_buf [2];
  logic       res_wr;
  logic       res_rd;
  logic [1:0] res_cnt;
  logic       res_full;
  logic       do_pop;

  assign res_full = (res_cnt == 2'd2);
  assign empty = (res_cnt == 2'd0);
  assign result = res_buf[res_rd];
  assign do_pop = pop && !empty;

  // The slot after the newest stamp; head plus count stays below twice the depth.
  always_comb begin
    tail_sum = 32'(wh) + 32'(wc);
    if (tail_sum >= ENTRIES) begin
      tail_sum = tail_sum - ENTRIES;
    end
    tail_slot = SLOT_W'(tail_sum);
    rd_addr = ADDR_W'(32'(st_client) * ENTRIES + 32'(wh));
    wr_addr = ADDR_W'(32'(st_client) * ENTRIES + 32'(tail_slot));
    age = st_now - mem_q;
  end

  always_comb begin
    state_next = state;
    wh_next = wh;
    wc_next = wc;
    cmd_take = 1'b0;
    mem_rd = 1'b0;
    mem_wr = 1'b0;
    ring_upd = 1'b0;
    res_push = 1'b0;
    res_allowed = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          wh_next = ring_head[cmd.client];
          wc_next = ring_count[cmd.client];
          // A zero limit denies without dropping any stamps.
          state_next = (cmd.limit == '0) ? S_DECIDE : S_PROBE;
        end
      end
      S_PROBE: begin
        if (wc == '0) begin
          state_next = S_DECIDE;
        end else begin
          mem_rd = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (age >= window_length) begin
          wh_next = (wh == SLOT_W'(ENTRIES - 1)) ? '0 : wh + SLOT_W'(1);
          wc_next = wc - CNT_W'(1);
          state_next = S_PROBE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_allowed = (st_limit != '0) && (wc < st_limit);
        if (!res_full) begin
          res_push = 1'b1;
          ring_upd = 1'b1;
          if (res_allowed) begin
            mem_wr = 1'b1;
            wc_next = wc + CNT_W'(1);
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      st_client <= cmd.client;
      st_limit <= cmd.limit;
      st_now <= cmd.now;
    end
    wh <= wh_next;
    wc <= wc_next;
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_addr] <= st_now;
    end
    if (mem_rd) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLIENTS; i++) begin
        ring_head[i] <= '0;
        ring_count[i] <= '0;
      end
    end else if (ring_upd) begin
      ring_head[st_client] <= wh;
      ring_count[st_client] <= wc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_buf[res_wr].allowed <= res_allowed;
      res_buf[res_wr].in_window_count <= 5'(wc_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr <= 1'b0;
      res_rd <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr <= ~res_wr;
      end
      if (do_pop) begin
        res_rd <= ~res_rd;
      end
      if (res_push && !do_pop) begin
        res_cnt <= res_cnt + 2'd1;
      end else if (!res_push && do_pop) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

endmodule

[rtl/core/sliding_window_rate_limiter.sv]
// Per-client sliding-window rate limiter with queue-style ports on both sides.
// A request (client index, optional limit, current time) is taken when push is
// high and full is low. Each request yields one result (allowed flag and the
// client's stored stamp count), shown while empty is low and taken by pop.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0 is
// the default limit, index 1 the window length in milliseconds.
// A request goes through a two-entry command queue into a sequencer that reads
// the client's stamps from a single-port memory. The sequencer takes a command
// in IDLE, then alternates PROBE (read the oldest stamp, or finish on an empty
// ring) and COMPARE (drop the stamp if expired), and ends in DECIDE once a live
// stamp or an empty ring stops the scan; a zero limit goes straight to DECIDE.
// It takes the next command only after DECIDE, while the command queue can
// accept new requests meanwhile.
// Reset clears the ring pointers of all clients and both queues and restores
// the default limit of 10 and the window of 1000; the stamp memory needs no
// clearing. When the receiver stalls, results collect in a two-entry output
// queue, then the sequencer and the command queue fill and full rises.
module sliding_window_rate_limiter
  import swrl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  req_t                   request,
  output logic                   empty,
  input  logic                   pop,
  output rsp_t                   result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [4:0]  default_limit;
  logic [31:0] window_length;
  logic        cmd_valid;
  logic        cmd_take;
  cmd_t        cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_limit <= DEFAULT_LIMIT_RESET;
      window_length <= WINDOW_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_LIMIT: default_limit <= cfg_data[4:0];
        REG_WINDOW_LENGTH: window_length <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  swrl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .request       (request),
    .default_limit (default_limit),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take)
  );

  swrl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_take      (cmd_take),
    .window_length (window_length),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

endmodule
